// ----- hdl/rgbc_pkg.sv -----
package rgbc_pkg;

  localparam int BUCKET_SLOTS = 4;
  localparam int SLOT_W       = $clog2(BUCKET_SLOTS) > 0 ? $clog2(BUCKET_SLOTS) : 1;

  localparam int CH_W   = 16;
  localparam int SUM_W  = CH_W + 1;
  localparam int NUM_W  = 27;
  localparam int QUO_W  = 10;
  localparam int HUE_W  = 12;
  localparam int FRAC_W = 10;

  localparam logic [HUE_W-1:0] HUE_FULL    = 12'd2880;
  localparam logic [HUE_W-1:0] HUE_HALF    = 12'd1440;
  localparam logic [HUE_W-1:0] HUE_GREEN   = 12'd960;
  localparam logic [HUE_W-1:0] HUE_BLUE    = 12'd1920;
  localparam logic [9:0]       SCALE_FRAC  = 10'd1000;
  localparam logic [8:0]       SCALE_HUE   = 9'd480;

  localparam logic [2:0] REG_ACTIVE = 3'd4;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    logic [FRAC_W-1:0] lit_tol;
    logic [FRAC_W-1:0] lit_ctr;
    logic [FRAC_W-1:0] sat_tol;
    logic [FRAC_W-1:0] sat_ctr;
    logic [HUE_W-1:0]  hue_tol;
    logic [HUE_W-1:0]  hue_ctr;
  } bucket_t;

  typedef struct packed {
    logic    valid;
    sector_t sector;
    logic    neg;
    logic    gray;
  } side_t;

  typedef struct packed {
    logic              valid;
    logic [HUE_W-1:0]  hue;
    logic [FRAC_W-1:0] sat;
    logic [FRAC_W-1:0] lit;
  } hsl_t;

endpackage

// ----- hdl/rgbc_div.sv -----
module rgbc_div
  import rgbc_pkg::*;
(
  input  logic             clk,
  input  logic [NUM_W-1:0] num_i,
  input  logic [SUM_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  // Restoring divider, one quotient bit per stage, most significant first.
  // The quotient is known to fit in QUO_W bits.
  logic [NUM_W-1:0] rem_r [QUO_W];
  logic [SUM_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [SUM_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [NUM_W-1:0] trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign trial = NUM_W'(den_in) << (QUO_W - 1 - k);
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? rem_in - trial : rem_in;
      den_r[k] <= den_in;
      quo_r[k] <= {quo_in[QUO_W-2:0], ge};
    end
  end

  assign quo_o = quo_r[QUO_W-1];

endmodule

// ----- hdl/rgbc_match.sv -----
module rgbc_match
  import rgbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  hsl_t              hsl_i,
  input  bucket_t           bucket_i [BUCKET_SLOTS],
  input  logic [2:0]        active_i,
  output logic              valid_o,
  output logic              matched_o,
  output logic [SLOT_W-1:0] index_o,
  output hsl_t              hsl_o
);

  logic [BUCKET_SLOTS-1:0] hit_nxt;
  logic [BUCKET_SLOTS-1:0] hit_r;
  hsl_t                    hsl_r;
  logic                    valid_r;
  logic                    matched_r;
  logic [SLOT_W-1:0]       index_r;
  logic                    matched_nxt;
  logic [SLOT_W-1:0]       index_nxt;

  always_comb begin
    for (int i = 0; i < BUCKET_SLOTS; i++) begin
      logic [HUE_W-1:0]  dh;
      logic [HUE_W-1:0]  dhw;
      logic [FRAC_W-1:0] ds;
      logic [FRAC_W-1:0] dl;
      dh  = (hsl_i.hue > bucket_i[i].hue_ctr) ? hsl_i.hue - bucket_i[i].hue_ctr
                                               : bucket_i[i].hue_ctr - hsl_i.hue;
      // Going the other way around the circle is shorter past half a turn.
      if (dh > HUE_HALF) begin
        dhw = (HUE_FULL > dh) ? HUE_FULL - dh : dh - HUE_FULL;
      end else begin
        dhw = dh;
      end
      ds = (hsl_i.sat > bucket_i[i].sat_ctr) ? hsl_i.sat - bucket_i[i].sat_ctr
                                              : bucket_i[i].sat_ctr - hsl_i.sat;
      dl = (hsl_i.lit > bucket_i[i].lit_ctr) ? hsl_i.lit - bucket_i[i].lit_ctr
                                              : bucket_i[i].lit_ctr - hsl_i.lit;
      hit_nxt[i] = (3'(i) < active_i) && (dhw <= bucket_i[i].hue_tol) &&
                   (ds <= bucket_i[i].sat_tol) && (dl <= bucket_i[i].lit_tol);
    end
  end

  always_comb begin
    matched_nxt = 1'b0;
    index_nxt   = '0;
    for (int i = BUCKET_SLOTS - 1; i >= 0; i--) begin
      if (hit_r[i]) begin
        matched_nxt = 1'b1;
        index_nxt   = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hsl_r.valid <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      hsl_r.valid <= hsl_i.valid;
      valid_r     <= hsl_r.valid;
    end
    hsl_r.hue <= hsl_i.hue;
    hsl_r.sat <= hsl_i.sat;
    hsl_r.lit <= hsl_i.lit;
    hit_r     <= hit_nxt;
    matched_r <= matched_nxt;
    index_r   <= index_nxt;
    hsl_o     <= hsl_r;
  end

  assign valid_o   = valid_r;
  assign matched_o = matched_r;
  assign index_o   = index_r;

endmodule

// ----- hdl/rgbc_hsl_color_bucket_classifier_top.sv -----
// RGBC to HSL color bucket classifier.
//
// Input: drive in_red_raw, in_green_raw, in_blue_raw and in_clear_raw with
// start high; the sample is taken at that clock edge. busy is always low,
// so a new sample may be started in every cycle.
//
// Output: once a sample has passed through the pipeline, out_valid is high for
// one cycle with hue, saturation, lightness and the bucket match. One result
// leaves per cycle; the pipeline is a clamp stage, a min/max stage, a multiply
// stage, ten stages of three restoring dividers (one quotient bit each), a hue
// assembly stage and two bucket compare stages. The receiver cannot stall.
//
// Configuration: cfg_ready is always high. Index 0..3 writes a bucket
// descriptor, index 4 the number of active buckets; other indexes are
// ignored. Write only while no sample is in flight.
//
// Reset: synchronous, active low. All buckets and the active count clear
// and every transaction in flight is dropped.
module rgbc_hsl_color_bucket_classifier_top
  import rgbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CH_W-1:0]   in_red_raw,
  input  logic [CH_W-1:0]   in_green_raw,
  input  logic [CH_W-1:0]   in_blue_raw,
  input  logic [CH_W-1:0]   in_clear_raw,
  output logic              out_valid,
  output logic              out_matched,
  output logic [SLOT_W-1:0] out_bucket_index,
  output logic [HUE_W-1:0]  out_hue,
  output logic [FRAC_W-1:0] out_saturation,
  output logic [FRAC_W-1:0] out_lightness,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_wdata
);

  bucket_t    bucket_r [BUCKET_SLOTS];
  logic [2:0] active_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BUCKET_SLOTS; i++) begin
        bucket_r[i] <= '0;
      end
      active_r <= '0;
    end else if (cfg_valid) begin
      for (int i = 0; i < BUCKET_SLOTS; i++) begin
        if (cfg_index == 3'(i)) begin
          bucket_r[i] <= bucket_t'(cfg_wdata);
        end
      end
      if (cfg_index == REG_ACTIVE) begin
        active_r <= cfg_wdata[2:0];
      end
    end
  end

  // Stage 1: clamp.
  logic [CH_W-1:0] c_nxt;
  logic [CH_W-1:0] r1_r, g1_r, b1_r, c1_r;
  logic            v1_r;

  assign c_nxt = (in_clear_raw == '0) ? CH_W'(1) : in_clear_raw;

  always_ff @(posedge clk) begin
    v1_r <= rst_n && start && !busy;
    r1_r <= (in_red_raw   > c_nxt) ? c_nxt : in_red_raw;
    g1_r <= (in_green_raw > c_nxt) ? c_nxt : in_green_raw;
    b1_r <= (in_blue_raw  > c_nxt) ? c_nxt : in_blue_raw;
    c1_r <= c_nxt;
  end

  // Stage 2: extremes, sector and divisors.
  logic [CH_W-1:0]  mx_nxt, mn_nxt, mag_nxt;
  logic [SUM_W-1:0] sum_nxt, twoc_nxt;
  sector_t          sec_nxt;
  logic             neg_nxt;
  logic [CH_W-1:0]  pa, pb;
  logic [CH_W-1:0]  d2_r, mag2_r;
  logic [SUM_W-1:0] sum2_r, twoc2_r, den2_r;
  side_t            sd2_r;

  always_comb begin
    mx_nxt = r1_r;
    if (g1_r > mx_nxt) mx_nxt = g1_r;
    if (b1_r > mx_nxt) mx_nxt = b1_r;
    mn_nxt = r1_r;
    if (g1_r < mn_nxt) mn_nxt = g1_r;
    if (b1_r < mn_nxt) mn_nxt = b1_r;
    if (mx_nxt == r1_r) begin
      sec_nxt = SEC_RED;
      pa      = g1_r;
      pb      = b1_r;
    end else if (mx_nxt == g1_r) begin
      sec_nxt = SEC_GREEN;
      pa      = b1_r;
      pb      = r1_r;
    end else begin
      sec_nxt = SEC_BLUE;
      pa      = r1_r;
      pb      = g1_r;
    end
    neg_nxt  = pa < pb;
    mag_nxt  = neg_nxt ? pb - pa : pa - pb;
    sum_nxt  = SUM_W'(mx_nxt) + SUM_W'(mn_nxt);
    twoc_nxt = {c1_r, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd2_r.valid <= 1'b0;
    end else begin
      sd2_r.valid <= v1_r;
    end
    sd2_r.sector <= sec_nxt;
    sd2_r.neg    <= neg_nxt;
    sd2_r.gray   <= mx_nxt == mn_nxt;
    d2_r         <= mx_nxt - mn_nxt;
    mag2_r       <= mag_nxt;
    sum2_r       <= sum_nxt;
    twoc2_r      <= twoc_nxt;
    // c - |sum - c| folds to the smaller of sum and 2c - sum.
    den2_r       <= (sum_nxt > SUM_W'(c1_r)) ? twoc_nxt - sum_nxt : sum_nxt;
  end

  // Stage 3: scale numerators.
  logic [NUM_W-1:0] nl3_r, ns3_r, nh3_r;
  logic [SUM_W-1:0] dl3_r, ds3_r, dh3_r;
  side_t            sd3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd3_r.valid <= 1'b0;
    end else begin
      sd3_r.valid <= sd2_r.valid;
    end
    sd3_r.sector <= sd2_r.sector;
    sd3_r.neg    <= sd2_r.neg;
    sd3_r.gray   <= sd2_r.gray;
    nl3_r        <= NUM_W'(sum2_r) * NUM_W'(SCALE_FRAC);
    ns3_r        <= NUM_W'(d2_r) * NUM_W'(SCALE_FRAC);
    nh3_r        <= NUM_W'(mag2_r) * NUM_W'(SCALE_HUE);
    dl3_r        <= twoc2_r;
    ds3_r        <= den2_r;
    dh3_r        <= SUM_W'(d2_r);
  end

  logic [QUO_W-1:0] ql, qs, qh;

  rgbc_div u_div_lit (.clk(clk), .num_i(nl3_r), .den_i(dl3_r), .quo_o(ql));
  rgbc_div u_div_sat (.clk(clk), .num_i(ns3_r), .den_i(ds3_r), .quo_o(qs));
  rgbc_div u_div_hue (.clk(clk), .num_i(nh3_r), .den_i(dh3_r), .quo_o(qh));

  side_t sd_r [QUO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_r[0].valid <= 1'b0;
    end else begin
      sd_r[0].valid <= sd3_r.valid;
    end
    sd_r[0].sector <= sd3_r.sector;
    sd_r[0].neg    <= sd3_r.neg;
    sd_r[0].gray   <= sd3_r.gray;
    for (int k = 1; k < QUO_W; k++) begin
      if (!rst_n) begin
        sd_r[k].valid <= 1'b0;
      end else begin
        sd_r[k].valid <= sd_r[k-1].valid;
      end
      sd_r[k].sector <= sd_r[k-1].sector;
      sd_r[k].neg    <= sd_r[k-1].neg;
      sd_r[k].gray   <= sd_r[k-1].gray;
    end
  end

  // Hue assembly.
  side_t            sdq;
  logic [HUE_W-1:0] base;
  logic [HUE_W:0]   hraw;
  logic [HUE_W-1:0] hue_nxt;
  hsl_t             hsl_r;

  assign sdq = sd_r[QUO_W-1];

  always_comb begin
    case (sdq.sector)
      SEC_GREEN: base = HUE_GREEN;
      SEC_BLUE:  base = HUE_BLUE;
      default:   base = '0;
    endcase
    if (sdq.neg) begin
      hraw = (HUE_W+1)'(base) + (HUE_W+1)'(HUE_FULL) - (HUE_W+1)'(qh);
    end else begin
      hraw = (HUE_W+1)'(base) + (HUE_W+1)'(qh);
    end
    if (hraw >= (HUE_W+1)'(HUE_FULL)) begin
      hue_nxt = HUE_W'(hraw - (HUE_W+1)'(HUE_FULL));
    end else begin
      hue_nxt = HUE_W'(hraw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hsl_r.valid <= 1'b0;
    end else begin
      hsl_r.valid <= sdq.valid;
    end
    hsl_r.hue <= sdq.gray ? '0 : hue_nxt;
    hsl_r.sat <= sdq.gray ? '0 : qs;
    hsl_r.lit <= ql;
  end

  hsl_t hsl_out;

  rgbc_match u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .hsl_i     (hsl_r),
    .bucket_i  (bucket_r),
    .active_i  (active_r),
    .valid_o   (out_valid),
    .matched_o (out_matched),
    .index_o   (out_bucket_index),
    .hsl_o     (hsl_out)
  );

  assign out_hue        = hsl_out.hue;
  assign out_saturation = hsl_out.sat;
  assign out_lightness  = hsl_out.lit;

endmodule

// ----- hdl/rgbc_chk.sv -----
module rgbc_chk
  import rgbc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic [CH_W-1:0]   in_red_raw,
  input logic [CH_W-1:0]   in_green_raw,
  input logic [CH_W-1:0]   in_blue_raw,
  input logic [CH_W-1:0]   in_clear_raw,
  input logic              out_valid,
  input logic              out_matched,
  input logic [SLOT_W-1:0] out_bucket_index,
  input logic [HUE_W-1:0]  out_hue,
  input logic [FRAC_W-1:0] out_saturation,
  input logic [FRAC_W-1:0] out_lightness,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [2:0]        cfg_index,
  input logic [63:0]       cfg_wdata
);

  a_flush: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result transaction right after reset");

  a_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue < HUE_FULL)
    else $error("hue out of range");

  a_frac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_saturation <= SCALE_FRAC) && (out_lightness <= SCALE_FRAC))
    else $error("saturation or lightness out of range");

  a_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_matched) |-> out_bucket_index == '0)
    else $error("bucket index set without a match");

endmodule

bind rgbc_hsl_color_bucket_classifier_top rgbc_chk u_rgbc_chk (.*);

// ----- tb/rgbc_classifier_checker.sv -----
module rgbc_classifier_checker
  import rgbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [CH_W-1:0]   in_red_raw,
  input  logic [CH_W-1:0]   in_green_raw,
  input  logic [CH_W-1:0]   in_blue_raw,
  input  logic [CH_W-1:0]   in_clear_raw,
  input  logic              out_valid,
  input  logic              out_matched,
  input  logic [SLOT_W-1:0] out_bucket_index,
  input  logic [HUE_W-1:0]  out_hue,
  input  logic [FRAC_W-1:0] out_saturation,
  input  logic [FRAC_W-1:0] out_lightness,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_wdata,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic              matched;
    logic [SLOT_W-1:0] idx;
    logic [HUE_W-1:0]  hue;
    logic [FRAC_W-1:0] sat;
    logic [FRAC_W-1:0] lit;
  } color_result_t;

  logic [63:0]   bucket_table [BUCKET_SLOTS];
  logic [2:0]    active_count;
  color_result_t expected_colors [$];

  function automatic longint unsigned udiff(longint unsigned a, longint unsigned b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic longint sext_offset(longint num, longint unsigned d);
    longint unsigned mag;
    longint q;
    mag = num < 0 ? -num : num;
    q = (480 * mag) / d;
    return num < 0 ? -q : q;
  endfunction

  function automatic color_result_t classify_color(logic [15:0] r_in, logic [15:0] g_in,
                                                   logic [15:0] b_in, logic [15:0] c_in);
    longint unsigned c, r, g, b, mx, mn, d, sum, hue, sat, lit, n, dh;
    longint h;
    color_result_t res;
    bucket_t bk;
    c = 64'(c_in); r = 64'(r_in); g = 64'(g_in); b = 64'(b_in);
    hue = 0; sat = 0;
    res = '0;
    if (c == 0) c = 1;
    if (r > c) r = c;
    if (g > c) g = c;
    if (b > c) b = c;
    mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
    mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
    d = mx - mn;
    sum = mx + mn;
    lit = (1000 * sum) / (2 * c);
    if (d > 0) begin
      sat = (1000 * d) / (c - udiff(sum, c));
      // Ties resolve red first, then green.
      if (mx == r) h = sext_offset(longint'(g) - longint'(b), d);
      else if (mx == g) h = 960 + sext_offset(longint'(b) - longint'(r), d);
      else h = 1920 + sext_offset(longint'(r) - longint'(g), d);
      if (h < 0) h += 2880;
      if (h >= 2880) h -= 2880;
      hue = h;
    end
    n = active_count > BUCKET_SLOTS ? BUCKET_SLOTS : active_count;
    for (int i = 0; i < n; i++) begin
      bk = bucket_t'(bucket_table[i]);
      dh = udiff(hue, bk.hue_ctr);
      if (dh > 1440) dh = udiff(2880, dh);
      if (!res.matched && dh <= bk.hue_tol && udiff(sat, bk.sat_ctr) <= bk.sat_tol &&
          udiff(lit, bk.lit_ctr) <= bk.lit_tol) begin
        res.matched = 1'b1;
        res.idx = SLOT_W'(i);
      end
    end
    res.hue = HUE_W'(hue);
    res.sat = FRAC_W'(sat);
    res.lit = FRAC_W'(lit);
    return res;
  endfunction

  assign pending = expected_colors.size();

  always @(posedge clk) begin
    color_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < BUCKET_SLOTS; i++) bucket_table[i] <= '0;
      active_count <= '0;
      fail_count <= 0;
      expected_colors.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < REG_ACTIVE) bucket_table[cfg_index[SLOT_W-1:0]] <= cfg_wdata;
        else if (cfg_index == REG_ACTIVE) active_count <= cfg_wdata[2:0];
      end
      if (start && !busy)
        expected_colors.push_back(classify_color(in_red_raw, in_green_raw,
                                                 in_blue_raw, in_clear_raw));
      if (out_valid) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected result transaction hue=%0d", $time, out_hue);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_colors.pop_front();
          if (want !== {out_matched, out_bucket_index, out_hue, out_saturation,
                        out_lightness}) begin
            $display("%0t: mismatch expected m=%0d i=%0d h=%0d s=%0d l=%0d",
                     $time, want.matched, want.idx, want.hue, want.sat, want.lit,
                     " actual m=%0d i=%0d h=%0d s=%0d l=%0d",
                     out_matched, out_bucket_index, out_hue, out_saturation,
                     out_lightness);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/tb_rgbc_hsl_color_bucket_classifier_top.sv -----
module tb_rgbc_hsl_color_bucket_classifier_top;
  import rgbc_pkg::*;

  localparam int PIPE_DEPTH = 16;
  localparam int IDLE_LIMIT = 5000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [CH_W-1:0]   in_red_raw = '0;
  logic [CH_W-1:0]   in_green_raw = '0;
  logic [CH_W-1:0]   in_blue_raw = '0;
  logic [CH_W-1:0]   in_clear_raw = '0;
  logic              out_valid;
  logic              out_matched;
  logic [SLOT_W-1:0] out_bucket_index;
  logic [HUE_W-1:0]  out_hue;
  logic [FRAC_W-1:0] out_saturation;
  logic [FRAC_W-1:0] out_lightness;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [63:0]       cfg_wdata = '0;
  int                fail_count;
  int                pending;
  int                idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgbc_hsl_color_bucket_classifier_top DUT (.*);

  rgbc_classifier_checker checker_i (.*);

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] pack_bucket(int hc, int ht, int sc, int st, int lc, int lt);
    bucket_t bk;
    bk.hue_ctr = HUE_W'(hc); bk.hue_tol = HUE_W'(ht); bk.sat_ctr = FRAC_W'(sc);
    bk.sat_tol = FRAC_W'(st); bk.lit_ctr = FRAC_W'(lc); bk.lit_tol = FRAC_W'(lt);
    return bk;
  endfunction

  task automatic drain_pipe();
    while (pending != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // Drives one sample; start stays high when the next one follows at once.
  task automatic send_sample(input logic [15:0] r, g, b, c, input bit random_gap);
    int gap;
    start <= 1'b1;
    in_red_raw <= r; in_green_raw <= g; in_blue_raw <= b; in_clear_raw <= c;
    do @(posedge clk); while (busy);
    @(negedge clk);
    gap = 0;
    if (random_gap) begin
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(10, 60);
      else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic logic [15:0] rand_chan(logic [15:0] c);
    case ($urandom_range(0, 5))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, c));
    endcase
  endfunction

  task automatic load_random_table();
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(0, 3) == 0) write_reg(3'(i), {$urandom, $urandom});
      else write_reg(3'(i), pack_bucket($urandom_range(0, 2879), $urandom_range(20, 400),
                                        $urandom_range(0, 1000), $urandom_range(50, 500),
                                        $urandom_range(0, 1000), $urandom_range(50, 500)));
    end
    write_reg(REG_ACTIVE, 64'($urandom_range(0, 7)));
    if ($urandom_range(0, 1)) write_reg(3'($urandom_range(5, 7)), {$urandom, $urandom});
  endtask

  initial begin
    logic [15:0] c;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // Directed samples with reset table: nothing can match.
    send_sample(16'd100, 16'd50, 16'd10, 16'd0, 0);
    send_sample(16'd0, 16'd0, 16'd0, 16'd0, 0);
    start <= 1'b0;
    drain_pipe();
    write_reg(3'd0, pack_bucket(0, 200, 1000, 1000, 500, 500));
    write_reg(3'd1, pack_bucket(960, 300, 500, 500, 500, 500));
    write_reg(3'd2, pack_bucket(4095, 4095, 1023, 1023, 1023, 1023));
    write_reg(3'd3, '1);
    write_reg(REG_ACTIVE, 64'd7);
    write_reg(3'd5, '1);
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    send_sample(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 0);
    send_sample(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 0);
    send_sample(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 0);
    send_sample(16'd500, 16'd500, 16'd10, 16'd1000, 0);
    send_sample(16'd10, 16'd500, 16'd500, 16'd1000, 0);
    send_sample(16'd500, 16'd10, 16'd500, 16'd1000, 0);
    send_sample(16'd500, 16'd10, 16'd20, 16'd1000, 0);
    send_sample(16'd2000, 16'd3000, 16'd100, 16'd1000, 0);
    send_sample(16'd1, 16'd0, 16'd1, 16'd0, 0);
    send_sample(16'd0, 16'd0, 16'd0, 16'hFFFF, 0);
    send_sample(16'h5555, 16'hAAAA, 16'h1234, 16'hFFFF, 0);
    send_sample(16'hAAAA, 16'h5555, 16'hEDCB, 16'hFFFF, 0);
    start <= 1'b0;
    drain_pipe();
    write_reg(REG_ACTIVE, 64'd0);
    send_sample(16'd300, 16'd200, 16'd100, 16'd400, 0);
    start <= 1'b0;
    drain_pipe();
    for (int phase = 0; phase < 10; phase++) begin
      load_random_table();
      for (int k = 0; k < 190; k++) begin
        c = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        send_sample(rand_chan(c), rand_chan(c), rand_chan(c), c, 1);
      end
      start <= 1'b0;
      drain_pipe();
    end
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
